// ===== design/fssd_pkg.sv =====
package fssd_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned SEG_W     = 7;
    localparam int unsigned CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LANE_CODE   = 8'd1;

    localparam logic [BYTE_W-1:0] DIGIT_COUNT_RESET = 8'd4;
    localparam logic [BYTE_W-1:0] LANE_CODE_RESET   = 8'd108;

    localparam logic [BYTE_W-1:0] CHAR_H     = 8'h48;
    localparam logic [BYTE_W-1:0] CHAR_P     = 8'h50;
    localparam logic [BYTE_W-1:0] CHAR_R     = 8'h52;
    localparam logic [BYTE_W-1:0] CHAR_DASH  = 8'h2D;
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

    localparam logic [SEG_W-1:0] SEG_H     = 7'h76;
    localparam logic [SEG_W-1:0] SEG_P     = 7'h73;
    localparam logic [SEG_W-1:0] SEG_R     = 7'h31;
    localparam logic [SEG_W-1:0] SEG_DASH  = 7'h40;
    localparam logic [SEG_W-1:0] SEG_BLANK = 7'h00;

    localparam logic [SEG_W-1:0] DIGIT_SEG [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7C, 7'h07, 7'h7F, 7'h67
    };

    typedef struct packed {
        logic [BYTE_W-1:0] digit_count;
        logic [BYTE_W-1:0] lane_code;
    } fssd_cfg_t;

    typedef struct packed {
        logic             emit;
        logic             last;
        logic [SEG_W-1:0] pattern;
    } fssd_result_t;

    function automatic logic [SEG_W-1:0] seg_of(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] offs;
        logic [SEG_W-1:0]  seg;
        offs = c - CHAR_ZERO;
        seg  = SEG_BLANK;
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            seg = DIGIT_SEG[offs[3:0]];
        end
        else if (c == CHAR_H)
        begin
            seg = SEG_H;
        end
        else if (c == CHAR_P)
        begin
            seg = SEG_P;
        end
        else if (c == CHAR_R)
        begin
            seg = SEG_R;
        end
        else if (c == CHAR_DASH)
        begin
            seg = SEG_DASH;
        end
        return seg;
    endfunction

endpackage

// ===== design/fssd_cfg_regs.sv =====
module fssd_cfg_regs
    import fssd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [BYTE_W-1:0]    wr_data,
    output fssd_cfg_t            cfg
);

    fssd_cfg_t cfg_reg;
    fssd_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_DIGIT_COUNT: cfg_next.digit_count = wr_data;
                REG_LANE_CODE:   cfg_next.lane_code   = wr_data;
                default:         cfg_next             = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.digit_count <= DIGIT_COUNT_RESET;
            cfg_reg.lane_code   <= LANE_CODE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/fssd_frame_sync.sv =====
module fssd_frame_sync
    import fssd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [BYTE_W-1:0] rx_byte,
    input  fssd_cfg_t         cfg,
    output fssd_result_t      res
);

    typedef enum logic [2:0] {
        ST_HUNT_H    = 3'd0,
        ST_HUNT_P    = 3'd1,
        ST_HUNT_R    = 3'd2,
        ST_HUNT_LANE = 3'd3,
        ST_PAYLOAD   = 3'd4
    } sync_state_t;

    sync_state_t       state_reg;
    sync_state_t       state_next;
    logic [BYTE_W-1:0] digits_reg;
    logic [BYTE_W-1:0] digits_next;
    logic [BYTE_W-1:0] digits_inc;
    logic              last;

    assign digits_inc = digits_reg + 1'b1;
    assign last       = (digits_inc == cfg.digit_count);

    always_comb
    begin
        state_next  = state_reg;
        digits_next = digits_reg;
        case (state_reg)
            ST_HUNT_H:    state_next = (rx_byte == CHAR_H) ? ST_HUNT_P : ST_HUNT_H;
            ST_HUNT_P:    state_next = (rx_byte == CHAR_P) ? ST_HUNT_R : ST_HUNT_H;
            ST_HUNT_R:    state_next = (rx_byte == CHAR_R) ? ST_HUNT_LANE : ST_HUNT_H;
            ST_HUNT_LANE: state_next = (rx_byte == cfg.lane_code) ? ST_PAYLOAD : ST_HUNT_H;
            ST_PAYLOAD:
            begin
                if (last)
                begin
                    state_next  = ST_HUNT_H;
                    digits_next = '0;
                end
                else
                begin
                    digits_next = digits_inc;
                end
            end
            default:      state_next = (rx_byte == CHAR_H) ? ST_HUNT_P : ST_HUNT_H;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_HUNT_H;
            digits_reg <= '0;
        end
        else if (step)
        begin
            state_reg  <= state_next;
            digits_reg <= digits_next;
        end
    end

    assign res.emit    = (state_reg == ST_PAYLOAD);
    assign res.last    = last;
    assign res.pattern = seg_of(rx_byte);

    a_count_only_in_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_PAYLOAD) |-> (digits_reg == '0))
        else $error("digit counter nonzero outside payload");

    a_last_returns_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res.emit && res.last) |=> (state_reg == ST_HUNT_H))
        else $error("frame end did not restart the header hunt");

    a_lane_match_enters_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (step && state_reg == ST_HUNT_LANE && rx_byte == cfg.lane_code)
        |=> (state_reg == ST_PAYLOAD))
        else $error("header match did not enter payload");

endmodule

// ===== design/fssd_out_reg.sv =====
module fssd_out_reg
    import fssd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  fssd_result_t     res,
    input  logic             take,
    output logic             can_load,
    output logic             out_valid,
    output logic [SEG_W-1:0] out_pattern,
    output logic             out_last
);

    logic             valid_reg;
    logic             valid_next;
    logic [SEG_W-1:0] pattern_reg;
    logic             last_reg;

    assign can_load   = !valid_reg || take;
    assign valid_next = load ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pattern_reg <= res.pattern;
            last_reg    <= res.last;
        end
    end

    assign out_valid   = valid_reg;
    assign out_pattern = pattern_reg;
    assign out_last    = last_reg;

endmodule

// ===== design/framed_seven_segment_decoder_unit.sv =====
// channel   dir  payload                                   transaction
// s_axis    in   tdata[7:0] rx_byte                        tvalid & tready
// m_axis    out  tdata[6:0] segment_pattern, tlast frame   tvalid & tready
// cfg       in   cfg_index (0 digit_count, 1 lane_code),   cfg_valid & cfg_ready
//                cfg_data[7:0]
//
// one byte per cycle sustained while m_axis is not stalled; a byte is held in
// the input register, then its pattern sits in the output register
// header bytes produce no output transaction
// rst_n clears the header hunt, the digit counter and both valid flags, and
// loads digit_count 4 and lane_code 'l'; cfg_ready is always high
// a stall on m_axis holds only payload bytes; header bytes still drain
module framed_seven_segment_decoder_unit
    import fssd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] rx_byte
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,   // [6:0] segment_pattern, [7] zero
    output logic                 m_axis_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    fssd_cfg_t         cfg;
    fssd_result_t      res;
    logic              in_valid_reg;
    logic              in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_accept;
    logic              step;
    logic              can_load;
    logic [SEG_W-1:0]  out_pattern;

    assign cfg_ready = 1'b1;

    fssd_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign step          = in_valid_reg && (!res.emit || can_load);
    assign s_axis_tready = !in_valid_reg || step;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_valid_next = in_accept ? 1'b1 : (step ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    fssd_frame_sync u_sync (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (in_byte_reg),
        .cfg     (cfg),
        .res     (res)
    );

    fssd_out_reg u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (step && res.emit),
        .res         (res),
        .take        (m_axis_tready),
        .can_load    (can_load),
        .out_valid   (m_axis_tvalid),
        .out_pattern (out_pattern),
        .out_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, out_pattern};

    a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_axis_tready)
        else $error("input stage empty but not ready");

    a_header_byte_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !res.emit) |-> step)
        else $error("header byte stalled");

endmodule

// ===== sim/framed_seven_segment_decoder_unit_test.sv =====
module framed_seven_segment_decoder_unit_test
    import fssd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] HUNT_H      = 3'd0;
    localparam logic [2:0] HUNT_P      = 3'd1;
    localparam logic [2:0] HUNT_R      = 3'd2;
    localparam logic [2:0] HUNT_LANE   = 3'd3;
    localparam logic [2:0] IN_PAYLOAD  = 3'd4;

    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DIRECTED_ROWS = 23;

    typedef struct packed {
        logic [SEG_W-1:0] pattern;
        logic             last;
    } seg_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] rx;
        logic              typed;
        logic              emits;
        logic [SEG_W-1:0]  pattern;
        logic              last;
    } directed_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata = 8'h00;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;
    logic                 m_axis_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_data = 8'h00;

    framed_seven_segment_decoder_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // decoder state mirrored on the testbench side
    logic [BYTE_W-1:0] digit_count_reg = DIGIT_COUNT_RESET;
    logic [BYTE_W-1:0] lane_code_reg   = LANE_CODE_RESET;
    logic [2:0]        hunt_pos        = HUNT_H;
    logic [BYTE_W-1:0] frame_chars     = 8'd0;

    seg_item_t pattern_expect_q [$];
    int        mismatch_count = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        hold_requests = 0;
    int        hold_served = 0;
    int        hold_left = 0;
    int        quiet_cycles = 0;

    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{8'h00,           1'b1, 1'b0, 7'h00, 1'b0},
        '{8'hFF,           1'b1, 1'b0, 7'h00, 1'b0},
        '{CHAR_H,          1'b1, 1'b0, 7'h00, 1'b0},
        '{CHAR_P,          1'b1, 1'b0, 7'h00, 1'b0},
        '{CHAR_R,          1'b1, 1'b0, 7'h00, 1'b0},
        '{LANE_CODE_RESET, 1'b1, 1'b0, 7'h00, 1'b0},
        '{CHAR_ZERO,       1'b1, 1'b1, 7'h3F, 1'b0},
        '{CHAR_NINE,       1'b1, 1'b1, 7'h67, 1'b0},
        '{CHAR_H,          1'b1, 1'b1, 7'h76, 1'b0},
        '{CHAR_DASH,       1'b1, 1'b1, 7'h40, 1'b1},
        // broken header, the offending byte is not taken as a new start
        '{CHAR_H,          1'b0, 1'b0, 7'h00, 1'b0},
        '{CHAR_H,          1'b0, 1'b0, 7'h00, 1'b0},
        '{CHAR_P,          1'b0, 1'b0, 7'h00, 1'b0},
        '{CHAR_R,          1'b0, 1'b0, 7'h00, 1'b0},
        '{LANE_CODE_RESET, 1'b0, 1'b0, 7'h00, 1'b0},
        '{CHAR_H,          1'b0, 1'b0, 7'h00, 1'b0},
        '{CHAR_P,          1'b0, 1'b0, 7'h00, 1'b0},
        '{CHAR_R,          1'b0, 1'b0, 7'h00, 1'b0},
        '{LANE_CODE_RESET, 1'b0, 1'b0, 7'h00, 1'b0},
        '{CHAR_P,          1'b0, 1'b0, 7'h00, 1'b0},
        '{CHAR_R,          1'b0, 1'b0, 7'h00, 1'b0},
        '{8'hFF,           1'b0, 1'b0, 7'h00, 1'b0},
        '{8'h00,           1'b0, 1'b0, 7'h00, 1'b0}
    };

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [SEG_W-1:0] segment_for(input logic [BYTE_W-1:0] c);
        logic [SEG_W-1:0] seg;
        case (c)
            8'h30:     seg = 7'h3F;
            8'h31:     seg = 7'h06;
            8'h32:     seg = 7'h5B;
            8'h33:     seg = 7'h4F;
            8'h34:     seg = 7'h66;
            8'h35:     seg = 7'h6D;
            8'h36:     seg = 7'h7C;
            8'h37:     seg = 7'h07;
            8'h38:     seg = 7'h7F;
            8'h39:     seg = 7'h67;
            CHAR_H:    seg = 7'h76;
            CHAR_P:    seg = 7'h73;
            CHAR_R:    seg = 7'h31;
            CHAR_DASH: seg = 7'h40;
            default:   seg = 7'h00;
        endcase
        return seg;
    endfunction

    function automatic logic [BYTE_W-1:0] header_byte_wanted();
        logic [BYTE_W-1:0] want;
        case (hunt_pos)
            HUNT_P:    want = CHAR_P;
            HUNT_R:    want = CHAR_R;
            HUNT_LANE: want = lane_code_reg;
            default:   want = CHAR_H;
        endcase
        return want;
    endfunction

    task automatic advance_decoder(input logic [BYTE_W-1:0] rx, output logic emits,
                                   output seg_item_t item);
        logic [BYTE_W-1:0] want;
        emits = 1'b0;
        item  = '0;
        if (hunt_pos == IN_PAYLOAD)
        begin
            frame_chars  = frame_chars + 8'd1;
            item.pattern = segment_for(rx);
            item.last    = (frame_chars == digit_count_reg);
            emits        = 1'b1;
            if (item.last)
            begin
                frame_chars = 8'd0;
                hunt_pos    = HUNT_H;
            end
        end
        else
        begin
            want = header_byte_wanted();
            if (hunt_pos > HUNT_LANE)
            begin
                hunt_pos = HUNT_H;
            end
            hunt_pos = (rx == want) ? hunt_pos + 3'd1 : HUNT_H;
        end
    endtask

    // mostly well-formed headers and frames, some noise
    function automatic logic [BYTE_W-1:0] pick_byte();
        logic [BYTE_W-1:0] b;
        int                roll;
        roll = $urandom_range(99);
        b    = 8'($urandom_range(255));
        if (hunt_pos != IN_PAYLOAD)
        begin
            if (roll < 85)
            begin
                b = header_byte_wanted();
            end
        end
        else if (roll < 50)
        begin
            b = CHAR_ZERO + 8'($urandom_range(9));
        end
        else if (roll < 70)
        begin
            case ($urandom_range(3))
                0:       b = CHAR_H;
                1:       b = CHAR_P;
                2:       b = CHAR_R;
                default: b = CHAR_DASH;
            endcase
        end
        return b;
    endfunction

    task automatic send_rx(input logic [BYTE_W-1:0] rx);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rx;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        if (idx == REG_DIGIT_COUNT)
        begin
            digit_count_reg = data;
        end
        else if (idx == REG_LANE_CODE)
        begin
            lane_code_reg = data;
        end
    endtask

    task automatic settle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pattern_expect_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input int count, input int sender_pct, input int receiver_pct,
                             input bit with_hold);
        logic [BYTE_W-1:0] rx;
        logic              emits;
        seg_item_t         item;
        send_idle_pct  = sender_pct;
        recv_stall_pct = receiver_pct;
        @(negedge clk);
        cfg_valid <= 1'b0;
        for (int n = 0; n < count; n++)
        begin
            if (with_hold && n == 40)
            begin
                hold_requests++;
            end
            rx = pick_byte();
            send_rx(rx);
            advance_decoder(rx, emits, item);
            if (emits)
            begin
                pattern_expect_q.push_back(item);
            end
        end
        settle();
    endtask

    // receiver side, with an occasional long hold-off
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served++;
            hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_segments
        seg_item_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pattern_expect_q.size() == 0)
            begin
                $display("%0t: unexpected segment transaction expected none actual %h last %b",
                         $time, m_axis_tdata, m_axis_tlast);
                mismatch_count++;
            end
            else
            begin
                want = pattern_expect_q.pop_front();
                if (m_axis_tdata[SEG_W-1:0] !== want.pattern)
                begin
                    $display("%0t: segment_pattern expected %h actual %h",
                             $time, want.pattern, m_axis_tdata[SEG_W-1:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[7] !== 1'b0)
                begin
                    $display("%0t: tdata pad bit expected 0 actual %b", $time, m_axis_tdata[7]);
                    mismatch_count++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $display("%0t: frame_last expected %b actual %b",
                             $time, want.last, m_axis_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("framed_seven_segment_decoder_unit regression: fail");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        logic      emits;
        seg_item_t item;
        seg_item_t typed_item;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part at reset settings
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            send_rx(directed_rows[i].rx);
            advance_decoder(directed_rows[i].rx, emits, item);
            if (directed_rows[i].typed)
            begin
                if (directed_rows[i].emits)
                begin
                    typed_item.pattern = directed_rows[i].pattern;
                    typed_item.last    = directed_rows[i].last;
                    pattern_expect_q.push_back(typed_item);
                end
            end
            else if (emits)
            begin
                pattern_expect_q.push_back(item);
            end
        end
        settle();

        write_reg(REG_DIGIT_COUNT, 8'd1);
        write_reg(REG_LANE_CODE, 8'h00);
        run_phase(40, 0, 0, 1'b0);

        // long frames, left open at the phase end
        write_reg(REG_DIGIT_COUNT, 8'd255);
        write_reg(REG_LANE_CODE, 8'hFF);
        run_phase(60, 70, 0, 1'b0);

        // count dropped below the running counter, counter wraps
        write_reg(REG_DIGIT_COUNT, 8'd3);
        write_reg(REG_LANE_CODE, 8'($urandom_range(255)));
        run_phase(300, 0, 70, 1'b1);

        // zero count means 256 characters; stray indexes are ignored
        write_reg(8'hFF, 8'($urandom_range(255)));
        write_reg(REG_DIGIT_COUNT, 8'd0);
        write_reg(REG_LANE_CODE, CHAR_H);
        run_phase(50, 22, 22, 1'b0);

        write_reg(CFG_IDX_W'($urandom_range(255, 2)), 8'($urandom_range(255)));
        write_reg(REG_DIGIT_COUNT, 8'($urandom_range(8, 1)));
        write_reg(REG_LANE_CODE, 8'($urandom_range(255)));
        run_phase(40, 22, 22, 1'b0);

        if (mismatch_count == 0)
        begin
            $display("framed_seven_segment_decoder_unit regression: pass");
        end
        else
        begin
            $display("framed_seven_segment_decoder_unit regression: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/fssd_pkg.sv
design/fssd_cfg_regs.sv
design/fssd_frame_sync.sv
design/fssd_out_reg.sv
design/framed_seven_segment_decoder_unit.sv
sim/framed_seven_segment_decoder_unit_test.sv
